// File: rtl/core/zsp_pkg.sv
// Package for the zipmap stream parser.
// Holds the length prefix marks and the result record type; no dependencies.
package zsp_pkg;

    localparam logic [7:0] END_MARK = 8'hff;
    localparam logic [7:0] BIG_MARK = 8'hfd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_value;
        logic       last_of_string;
        logic       empty_string;
        logic       map_end;
        logic       bad_prefix;
    } result_t;

endpackage

// File: rtl/core/zipmap_stream_parser.sv
// Zipmap stream parser top level: input register, prefix/payload decode, result register.
// Depends on zsp_pkg.
//
// Takes one byte per cycle while in_stall is low and gives at most one result per
// byte, held first in the input register and then in the result register. The
// phase, 32-bit remaining length, extended-length byte index and free-byte count
// are updated in the single decode step between those two registers, so bytes
// stream back to back. in_stall rises only when a result waits in the output
// register under out_stall while a byte also waits in the input register.
// A byte with map_start set is a count byte and restarts parsing from any phase.
module zipmap_stream_parser
    import zsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       map_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_value,
    output logic       last_of_string,
    output logic       empty_string,
    output logic       map_end,
    output logic       bad_prefix
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_KEY_LEN  = 4'd1;
    localparam logic [3:0] PH_KEY_EXT  = 4'd2;
    localparam logic [3:0] PH_KEY_DATA = 4'd3;
    localparam logic [3:0] PH_VAL_LEN  = 4'd4;
    localparam logic [3:0] PH_VAL_EXT  = 4'd5;
    localparam logic [3:0] PH_FREE     = 4'd6;
    localparam logic [3:0] PH_VAL_DATA = 4'd7;
    localparam logic [3:0] PH_PAD      = 4'd8;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [1:0]  ext_idx_reg, ext_idx_next;
    logic [7:0]  free_left_reg, free_left_next;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;
    logic        res_valid;
    logic        adv;
    logic [31:0] ext_val;
    logic        last;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= in_byte;
            s1_start_reg <= map_start;
        end
    end

    always_comb
    begin
        ext_val = remaining_reg;
        case (ext_idx_reg)
            2'd0:    ext_val[7:0]   = s1_byte_reg;
            2'd1:    ext_val[15:8]  = s1_byte_reg;
            2'd2:    ext_val[23:16] = s1_byte_reg;
            default: ext_val[31:24] = s1_byte_reg;
        endcase
    end

    assign last = (remaining_reg <= 32'd1);

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        ext_idx_next   = ext_idx_reg;
        free_left_next = free_left_reg;
        res            = '0;
        res_valid      = 1'b0;
        if (s1_start_reg)
        begin
            phase_next     = PH_KEY_LEN;
            remaining_next = '0;
            ext_idx_next   = '0;
            free_left_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_KEY_LEN:
                begin
                    if (s1_byte_reg < BIG_MARK)
                    begin
                        remaining_next = {24'd0, s1_byte_reg};
                        if (s1_byte_reg == 8'd0)
                        begin
                            phase_next       = PH_VAL_LEN;
                            res.empty_string = 1'b1;
                            res_valid        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_KEY_DATA;
                        end
                    end
                    else if (s1_byte_reg == BIG_MARK)
                    begin
                        remaining_next = '0;
                        ext_idx_next   = '0;
                        phase_next     = PH_KEY_EXT;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (s1_byte_reg == END_MARK)
                        begin
                            res.map_end = 1'b1;
                        end
                        else
                        begin
                            res.bad_prefix = 1'b1;
                        end
                    end
                end
                PH_KEY_EXT:
                begin
                    remaining_next = ext_val;
                    ext_idx_next   = ext_idx_reg + 2'd1;
                    if (ext_idx_reg == 2'd3)
                    begin
                        if (ext_val == 32'd0)
                        begin
                            phase_next       = PH_VAL_LEN;
                            res.empty_string = 1'b1;
                            res_valid        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_KEY_DATA;
                        end
                    end
                end
                PH_KEY_DATA:
                begin
                    remaining_next     = last ? 32'd0 : remaining_reg - 32'd1;
                    res.out_byte       = s1_byte_reg;
                    res.last_of_string = last;
                    res_valid          = 1'b1;
                    if (last)
                    begin
                        phase_next = PH_VAL_LEN;
                    end
                end
                PH_VAL_LEN:
                begin
                    if (s1_byte_reg < BIG_MARK)
                    begin
                        remaining_next = {24'd0, s1_byte_reg};
                        phase_next     = PH_FREE;
                    end
                    else if (s1_byte_reg == BIG_MARK)
                    begin
                        remaining_next = '0;
                        ext_idx_next   = '0;
                        phase_next     = PH_VAL_EXT;
                    end
                    else
                    begin
                        phase_next     = PH_IDLE;
                        res.is_value   = 1'b1;
                        res.bad_prefix = 1'b1;
                        res_valid      = 1'b1;
                    end
                end
                PH_VAL_EXT:
                begin
                    remaining_next = ext_val;
                    ext_idx_next   = ext_idx_reg + 2'd1;
                    if (ext_idx_reg == 2'd3)
                    begin
                        phase_next = PH_FREE;
                    end
                end
                PH_FREE:
                begin
                    free_left_next = s1_byte_reg;
                    if (remaining_reg == 32'd0)
                    begin
                        phase_next       = (s1_byte_reg == 8'd0) ? PH_KEY_LEN : PH_PAD;
                        res.is_value     = 1'b1;
                        res.empty_string = 1'b1;
                        res_valid        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VAL_DATA;
                    end
                end
                PH_VAL_DATA:
                begin
                    remaining_next     = last ? 32'd0 : remaining_reg - 32'd1;
                    res.out_byte       = s1_byte_reg;
                    res.is_value       = 1'b1;
                    res.last_of_string = last;
                    res_valid          = 1'b1;
                    if (last)
                    begin
                        phase_next = (free_left_reg == 8'd0) ? PH_KEY_LEN : PH_PAD;
                    end
                end
                PH_PAD:
                begin
                    if (free_left_reg <= 8'd1)
                    begin
                        free_left_next = '0;
                        phase_next     = PH_KEY_LEN;
                    end
                    else
                    begin
                        free_left_next = free_left_reg - 8'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // advance parser state once per transaction leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            ext_idx_reg   <= '0;
            free_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && res_valid;
            if (s1_valid_reg)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                ext_idx_reg   <= ext_idx_next;
                free_left_reg <= free_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_reg.out_byte;
    assign is_value       = out_reg.is_value;
    assign last_of_string = out_reg.last_of_string;
    assign empty_string   = out_reg.empty_string;
    assign map_end        = out_reg.map_end;
    assign bad_prefix     = out_reg.bad_prefix;

    a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.map_end |->
            !out_reg.bad_prefix && !out_reg.empty_string && !out_reg.last_of_string)
        else $error("map end result carries other marks");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.empty_string |->
            out_reg.out_byte == 8'd0 && !out_reg.last_of_string)
        else $error("empty string result carries payload");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_valid_reg && res_valid && (res.map_end || res.bad_prefix) |=>
            phase_reg == PH_IDLE)
        else $error("parser not idle after map end or bad prefix");

    a_ext_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ext_idx_reg != 2'd0 |-> phase_reg == PH_KEY_EXT || phase_reg == PH_VAL_EXT)
        else $error("extended length index outside length phase");

endmodule

// File: tb/sv/zipmap_stream_parser_tb.sv
// Testbench for zipmap_stream_parser: directed table, then random zipmaps with noise.
// Results are checked against the typed rows of the table or an in-bench decoder.
// Depends on zsp_pkg and the zipmap_stream_parser RTL.
module zipmap_stream_parser_tb;
    import zsp_pkg::*;

    localparam logic [7:0] BAD_MARK = 8'hfe;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned HOLD_CYCLES = 64;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_KEY_LEN,
        PH_KEY_EXT,
        PH_KEY_DATA,
        PH_VAL_LEN,
        PH_VAL_EXT,
        PH_FREE,
        PH_VAL_DATA,
        PH_PAD
    } parse_phase_e;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       map_start;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RES      = '0;
    localparam result_t R_EMPTY_KEY = result_t'{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam result_t R_EMPTY_VAL = result_t'{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam result_t R_BAD_KEY   = result_t'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam result_t R_BAD_VAL   = result_t'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam result_t R_MAP_END   = result_t'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    localparam int unsigned NUM_ROWS = 28;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h03,    1'b1, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b1, R_EMPTY_KEY},
        '{BIG_MARK, 1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h01,    1'b0, 1'b1, R_EMPTY_VAL},
        '{END_MARK, 1'b0, 1'b0, NO_RES},
        '{8'h01,    1'b0, 1'b0, NO_RES},
        '{8'hff,    1'b0, 1'b0, NO_RES},
        '{8'h01,    1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b0, NO_RES},
        '{BIG_MARK, 1'b0, 1'b0, NO_RES},
        '{8'hff,    1'b0, 1'b0, NO_RES},
        '{8'hff,    1'b0, 1'b0, NO_RES},
        '{8'hff,    1'b0, 1'b0, NO_RES},
        '{8'hff,    1'b0, 1'b0, NO_RES},
        '{8'h5a,    1'b0, 1'b0, NO_RES},
        '{8'h01,    1'b1, 1'b0, NO_RES},
        '{BAD_MARK, 1'b0, 1'b1, R_BAD_KEY},
        '{8'h07,    1'b1, 1'b0, NO_RES},
        '{8'h00,    1'b0, 1'b1, R_EMPTY_KEY},
        '{BAD_MARK, 1'b0, 1'b1, R_BAD_VAL},
        '{8'h00,    1'b1, 1'b0, NO_RES},
        '{END_MARK, 1'b0, 1'b1, R_MAP_END}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       map_start = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       is_value;
    logic       last_of_string;
    logic       empty_string;
    logic       map_end;
    logic       bad_prefix;

    result_t      expected_results [$];
    int unsigned  err_count = 0;
    int unsigned  random_items = 0;
    int unsigned  src_idle_pct = 28;
    int unsigned  sink_idle_pct = 28;
    int unsigned  hold_req = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;

    parse_phase_e dec_phase = PH_IDLE;
    logic [31:0]  dec_remaining = '0;
    logic [1:0]   dec_ext_idx = '0;
    logic [7:0]   dec_free_left = '0;

    zipmap_stream_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .map_start      (map_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_value       (is_value),
        .last_of_string (last_of_string),
        .empty_string   (empty_string),
        .map_end        (map_end),
        .bad_prefix     (bad_prefix)
    );

    always #4 clk = ~clk;

    function automatic bit take_len_byte(input logic [7:0] b);
        dec_remaining |= 32'(b) << (8 * dec_ext_idx);
        if (dec_ext_idx == 2'd3)
        begin
            dec_ext_idx = 2'd0;
            return 1'b1;
        end
        dec_ext_idx++;
        return 1'b0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic s, output result_t r);
        bit last;
        r = '0;
        if (s)
        begin
            dec_phase = PH_KEY_LEN;
            dec_remaining = '0;
            dec_ext_idx = '0;
            dec_free_left = '0;
            return 1'b0;
        end
        case (dec_phase)
            PH_KEY_LEN:
            begin
                if (b < BIG_MARK)
                begin
                    dec_remaining = 32'(b);
                    if (b == 8'h00)
                    begin
                        dec_phase = PH_VAL_LEN;
                        r.empty_string = 1'b1;
                        return 1'b1;
                    end
                    dec_phase = PH_KEY_DATA;
                    return 1'b0;
                end
                if (b == BIG_MARK)
                begin
                    dec_remaining = '0;
                    dec_ext_idx = '0;
                    dec_phase = PH_KEY_EXT;
                    return 1'b0;
                end
                dec_phase = PH_IDLE;
                if (b == END_MARK)
                    r.map_end = 1'b1;
                else
                    r.bad_prefix = 1'b1;
                return 1'b1;
            end
            PH_KEY_EXT:
            begin
                if (!take_len_byte(b))
                    return 1'b0;
                if (dec_remaining == 0)
                begin
                    dec_phase = PH_VAL_LEN;
                    r.empty_string = 1'b1;
                    return 1'b1;
                end
                dec_phase = PH_KEY_DATA;
                return 1'b0;
            end
            PH_KEY_DATA:
            begin
                last = (dec_remaining <= 1);
                dec_remaining = last ? '0 : dec_remaining - 1;
                if (last)
                    dec_phase = PH_VAL_LEN;
                r.out_byte = b;
                r.last_of_string = last;
                return 1'b1;
            end
            PH_VAL_LEN:
            begin
                if (b < BIG_MARK)
                begin
                    dec_remaining = 32'(b);
                    dec_phase = PH_FREE;
                    return 1'b0;
                end
                if (b == BIG_MARK)
                begin
                    dec_remaining = '0;
                    dec_ext_idx = '0;
                    dec_phase = PH_VAL_EXT;
                    return 1'b0;
                end
                dec_phase = PH_IDLE;
                r.is_value = 1'b1;
                r.bad_prefix = 1'b1;
                return 1'b1;
            end
            PH_VAL_EXT:
            begin
                if (take_len_byte(b))
                    dec_phase = PH_FREE;
                return 1'b0;
            end
            PH_FREE:
            begin
                dec_free_left = b;
                if (dec_remaining == 0)
                begin
                    dec_phase = (dec_free_left == 0) ? PH_KEY_LEN : PH_PAD;
                    r.is_value = 1'b1;
                    r.empty_string = 1'b1;
                    return 1'b1;
                end
                dec_phase = PH_VAL_DATA;
                return 1'b0;
            end
            PH_VAL_DATA:
            begin
                last = (dec_remaining <= 1);
                dec_remaining = last ? '0 : dec_remaining - 1;
                if (last)
                    dec_phase = (dec_free_left == 0) ? PH_KEY_LEN : PH_PAD;
                r.out_byte = b;
                r.is_value = 1'b1;
                r.last_of_string = last;
                return 1'b1;
            end
            PH_PAD:
            begin
                if (dec_free_left <= 1)
                begin
                    dec_free_left = '0;
                    dec_phase = PH_KEY_LEN;
                end
                else
                    dec_free_left--;
                return 1'b0;
            end
            default:
            begin
                dec_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result, out_byte %0h", out_byte));
            else
            begin
                want = expected_results.pop_front();
                check_field("out_byte", out_byte, want.out_byte);
                check_field("is_value", 8'(is_value), 8'(want.is_value));
                check_field("last_of_string", 8'(last_of_string), 8'(want.last_of_string));
                check_field("empty_string", 8'(empty_string), 8'(want.empty_string));
                check_field("map_end", 8'(map_end), 8'(want.map_end));
                check_field("bad_prefix", 8'(bad_prefix), 8'(want.bad_prefix));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // Offer one transaction, hold it until accepted, then maybe idle.
    task automatic drive_byte(input logic [7:0] b, input logic s, input logic typed,
                              input result_t want);
        result_t pred;
        bit      has;
        bit      counts;
        in_byte <= b;
        map_start <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        counts = s || (dec_phase != PH_IDLE);
        has = decode_byte(b, s, pred);
        if (typed)
            expected_results.push_back(want);
        else if (has)
            expected_results.push_back(pred);
        if (counts)
            random_items++;
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        drive_byte(b, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(0, 6);
        if (r < 93)
            return $urandom_range(7, 40);
        return $urandom_range(200, 300);
    endfunction

    task automatic send_len(input int unsigned len);
        if (len < BIG_MARK && $urandom_range(99) < 85)
            put_byte(len[7:0]);
        else
        begin
            put_byte(BIG_MARK);
            for (int i = 0; i < 4; i++)
                put_byte(8'(len >> (8 * i)));
        end
    endtask

    task automatic send_payload(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            put_byte(8'($urandom));
    endtask

    task automatic send_map(input int unsigned min_pairs);
        int unsigned pairs;
        int unsigned len;
        int unsigned free_cnt;
        int unsigned r;
        drive_byte(8'($urandom), 1'b1, 1'b0, NO_RES);
        pairs = $urandom_range(min_pairs, min_pairs + 5);
        for (int unsigned p = 0; p < pairs; p++)
        begin
            len = pick_len();
            send_len(len);
            send_payload(len);
            len = pick_len();
            send_len(len);
            r = $urandom_range(99);
            free_cnt = (r < 75) ? 0 : (r < 97) ? $urandom_range(1, 3) : $urandom_range(0, 255);
            put_byte(8'(free_cnt));
            send_payload(len);
            send_payload(free_cnt);
        end
        r = $urandom_range(99);
        if (r < 78)
            put_byte(END_MARK);
        else if (r < 84)
            put_byte(BAD_MARK);
        else if (r < 90)
        begin
            len = $urandom_range(0, 5);
            send_len(len);
            send_payload(len);
            put_byte(($urandom_range(1) != 0) ? BAD_MARK : END_MARK);
        end
        else if (r < 95)
        begin
            send_len(10);
            send_payload($urandom_range(0, 9));
        end
        else
            send_payload($urandom_range(1, 12));
        if ($urandom_range(99) < 15)
            send_payload($urandom_range(1, 3));
    endtask

    initial
    begin
        int unsigned map_idx;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            drive_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].map_start,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        drain_results();

        random_items = 0;
        map_idx = 0;
        while (random_items < RANDOM_ITEMS || map_idx < 5)
        begin
            if (map_idx == 1)
            begin
                src_idle_pct <= 0;
                sink_idle_pct <= 0;
            end
            else if (map_idx == 2 || map_idx == 4)
            begin
                src_idle_pct <= 28;
                sink_idle_pct <= 28;
            end
            if (map_idx == 3)
            begin
                src_idle_pct <= 0;
                hold_req <= hold_req + 1;
                send_map(4);
            end
            else
                send_map(0);
            if (map_idx == 3 || $urandom_range(99) < 8)
                drain_results();
            map_idx++;
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
